/* rtl/kprt_pkg.sv */
// Shared widths, event codes, register indexes and control types for the key tracker.
`timescale 1ns / 1ps

package kprt_pkg;

    // Field widths fixed by the channel formats
    localparam int MASK_W    = 12;
    localparam int NOW_W     = 32;
    localparam int ID_W      = 4;
    localparam int KIND_W    = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Default sizing handed to the top level
    localparam int NUM_BUTTONS_DEF = 12;
    localparam int TIME_BITS_DEF   = 32;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPEAT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] RELEASE_TIMEOUT_RST = 16'd150;
    localparam logic [CFG_W-1:0] REPEAT_DELAY_RST    = 16'd400;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd50;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_step;
        logic emit_step;
    } kprt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic emit_last;
    } kprt_status_t;

endpackage

/* rtl/kprt_ifs.sv */
// Channel interfaces of the key tracker: poll input, event output, register writes.
`timescale 1ns / 1ps

interface kprt_poll_if;
    logic                       valid;
    logic                       ready;
    logic [kprt_pkg::MASK_W-1:0] pressed_mask;
    logic [kprt_pkg::NOW_W-1:0]  now_ms;

    modport source (output valid, output pressed_mask, output now_ms, input ready);
    modport sink   (input valid, input pressed_mask, input now_ms, output ready);
endinterface

interface kprt_event_if;
    logic                        valid;
    logic                        ready;
    logic [kprt_pkg::ID_W-1:0]   button_id;
    logic [kprt_pkg::KIND_W-1:0] event_kind;
    logic [kprt_pkg::MASK_W-1:0] held_mask;
    logic                        last;

    modport source (output valid, output button_id, output event_kind,
                    output held_mask, output last, input ready);
    modport sink   (input valid, input button_id, input event_kind,
                    input held_mask, input last, output ready);
endinterface

interface kprt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kprt_pkg::CFG_IDX_W-1:0] index;
    logic [kprt_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/key_press_repeat_release_tracker.sv */
// Top level of the key press, repeat and release tracker.
// Usage:
//   poll : one beat per poll, pressed_mask of buttons seen and the now_ms timestamp.
//   evt  : one beat per press, repeat or release event of that poll, in button
//          order, each with the held mask after the whole poll; last marks the
//          final beat. A poll with no events gives one beat of kind none.
//   cfg  : register writes (release timeout, repeat delay, repeat interval),
//          always ready; write only while no poll is in progress.
// Timing:
//   After a poll beat is taken, the scan visits one button per cycle, and the
//   first event beat is offered once the last button is scanned. Event beats
//   then go out one per cycle while evt.ready is high. The next poll can be
//   taken in the cycle after the last event beat, so no new poll is taken
//   before every event beat of the previous one is out. The scan of the
//   button state, one button at a time, sets the poll rate.
// Reset:
//   Registers return to 150, 400 and 50 ms; all buttons are released and all
//   recorded times are zero. poll.ready rises in the first cycle after reset.
// Stall:
//   A held-off event beat stays on evt unchanged and no new poll is taken.
`timescale 1ns / 1ps

module key_press_repeat_release_tracker #(
    parameter int NUM_BUTTONS = kprt_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = kprt_pkg::TIME_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    kprt_poll_if.sink   poll,
    kprt_event_if.source evt,
    kprt_cfg_if.sink    cfg
);

    kprt_pkg::kprt_cmd_t    cmd;
    kprt_pkg::kprt_status_t status;

    // Sequence the poll through accept, scan and emit
    kprt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll_valid (poll.valid),
        .poll_ready (poll.ready),
        .evt_valid  (evt.valid),
        .evt_ready  (evt.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Hold button state and build the events
    kprt_datapath #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pressed_mask (poll.pressed_mask),
        .now_ms       (poll.now_ms),
        .button_id    (evt.button_id),
        .event_kind   (evt.event_kind),
        .held_mask    (evt.held_mask),
        .last         (evt.last),
        .cfg_valid    (cfg.valid),
        .cfg_ready    (cfg.ready),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data)
    );

endmodule

/* rtl/kprt_ctrl.sv */
// Controller state machine: accept a poll, scan the buttons, emit the events.
`timescale 1ns / 1ps

module kprt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   poll_valid,
    output logic                   poll_ready,
    output logic                   evt_valid,
    input  logic                   evt_ready,
    input  kprt_pkg::kprt_status_t status,
    output kprt_pkg::kprt_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   poll_ready_reg;
    logic   evt_valid_reg;

    // Decode commands from the current state and handshakes
    always_comb
    begin
        cmd.load      = poll_valid && poll_ready_reg;
        cmd.scan_step = (state_reg == ST_SCAN);
        cmd.emit_step = evt_valid_reg && evt_ready;
    end

    // Pick the next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit_step && status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            poll_ready_reg <= 1'b0;
            evt_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            poll_ready_reg <= (state_next == ST_IDLE);
            evt_valid_reg  <= (state_next == ST_EMIT);
        end
    end

    assign poll_ready = poll_ready_reg;
    assign evt_valid  = evt_valid_reg;

endmodule

/* rtl/kprt_datapath.sv */
// Datapath: button state, registers, one-button-per-cycle event scan and event buffer.
`timescale 1ns / 1ps

module kprt_datapath #(
    parameter int NUM_BUTTONS = kprt_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = kprt_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kprt_pkg::kprt_cmd_t             cmd,
    output kprt_pkg::kprt_status_t          status,
    input  logic [kprt_pkg::MASK_W-1:0]     pressed_mask,
    input  logic [kprt_pkg::NOW_W-1:0]      now_ms,
    output logic [kprt_pkg::ID_W-1:0]       button_id,
    output logic [kprt_pkg::KIND_W-1:0]     event_kind,
    output logic [kprt_pkg::MASK_W-1:0]     held_mask,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kprt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kprt_pkg::CFG_W-1:0]      cfg_data
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CNT_W = $clog2(NUM_BUTTONS + 1);

    // Registers
    logic [kprt_pkg::CFG_W-1:0] release_timeout_reg;
    logic [kprt_pkg::CFG_W-1:0] repeat_delay_reg;
    logic [kprt_pkg::CFG_W-1:0] repeat_interval_reg;

    // Per-button state
    logic [NUM_BUTTONS-1:0] held_reg;
    logic [TIME_BITS-1:0]   seen_time_reg   [NUM_BUTTONS];
    logic [TIME_BITS-1:0]   start_time_reg  [NUM_BUTTONS];
    logic [TIME_BITS-1:0]   repeat_time_reg [NUM_BUTTONS];

    // Poll working state and compacted event buffer
    logic [TIME_BITS-1:0]           now_reg;
    logic [IDX_W-1:0]               scan_idx_reg;
    logic [IDX_W-1:0]               emit_idx_reg;
    logic [CNT_W-1:0]               ev_cnt_reg;
    logic [IDX_W-1:0]               ev_id_reg   [NUM_BUTTONS];
    logic [kprt_pkg::KIND_W-1:0]    ev_kind_reg [NUM_BUTTONS];

    logic [NUM_BUTTONS-1:0]         seen_vec;
    logic [TIME_BITS-1:0]           now_ext;
    logic [TIME_BITS-1:0]           d_start;
    logic [TIME_BITS-1:0]           d_repeat;
    logic [TIME_BITS-1:0]           d_seen;
    logic [kprt_pkg::KIND_W-1:0]    scan_kind;
    logic [IDX_W-1:0]               ev_wr_idx;

    assign seen_vec  = NUM_BUTTONS'(pressed_mask);
    assign now_ext   = TIME_BITS'(now_ms);
    assign ev_wr_idx = ev_cnt_reg[IDX_W-1:0];
    assign cfg_ready = 1'b1;

    // Classify the button under the scan index
    always_comb
    begin
        d_start   = now_reg - start_time_reg[scan_idx_reg];
        d_repeat  = now_reg - repeat_time_reg[scan_idx_reg];
        d_seen    = now_reg - seen_time_reg[scan_idx_reg];
        scan_kind = kprt_pkg::KIND_NONE;
        if (held_reg[scan_idx_reg])
        begin
            if (d_start == '0)
            begin
                scan_kind = kprt_pkg::KIND_PRESS;
            end
            else if ((d_start >= TIME_BITS'(repeat_delay_reg)) &&
                     (d_repeat >= TIME_BITS'(repeat_interval_reg)))
            begin
                scan_kind = kprt_pkg::KIND_REPEAT;
            end
            else if (d_seen > TIME_BITS'(release_timeout_reg))
            begin
                scan_kind = kprt_pkg::KIND_RELEASE;
            end
        end
    end

    // Report scan end and final event to the controller
    always_comb
    begin
        status.scan_last = (scan_idx_reg == IDX_W'(NUM_BUTTONS - 1));
        status.emit_last = (ev_cnt_reg == '0) ||
                           ((CNT_W'(emit_idx_reg) + CNT_W'(1)) == ev_cnt_reg);
    end

    // Take register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_timeout_reg <= kprt_pkg::RELEASE_TIMEOUT_RST;
            repeat_delay_reg    <= kprt_pkg::REPEAT_DELAY_RST;
            repeat_interval_reg <= kprt_pkg::REPEAT_INTERVAL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                kprt_pkg::CFG_RELEASE_TIMEOUT: release_timeout_reg <= cfg_data;
                kprt_pkg::CFG_REPEAT_DELAY:    repeat_delay_reg    <= cfg_data;
                kprt_pkg::CFG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Latch the poll into button state, then advance the scan one button a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            now_reg      <= '0;
            scan_idx_reg <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                seen_time_reg[i]   <= '0;
                start_time_reg[i]  <= '0;
                repeat_time_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            now_reg      <= now_ext;
            scan_idx_reg <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                if (seen_vec[i])
                begin
                    if (!held_reg[i])
                    begin
                        start_time_reg[i] <= now_ext;
                    end
                    held_reg[i]      <= 1'b1;
                    seen_time_reg[i] <= now_ext;
                end
            end
        end
        else if (cmd.scan_step)
        begin
            if (!status.scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            if (scan_kind == kprt_pkg::KIND_REPEAT)
            begin
                repeat_time_reg[scan_idx_reg] <= now_reg;
            end
            if (scan_kind == kprt_pkg::KIND_RELEASE)
            begin
                held_reg[scan_idx_reg] <= 1'b0;
            end
        end
    end

    // Count events and walk the emit index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_cnt_reg   <= '0;
            emit_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            ev_cnt_reg   <= '0;
            emit_idx_reg <= '0;
        end
        else
        begin
            if (cmd.scan_step && (scan_kind != kprt_pkg::KIND_NONE))
            begin
                ev_cnt_reg <= ev_cnt_reg + CNT_W'(1);
            end
            if (cmd.emit_step && !status.emit_last)
            begin
                emit_idx_reg <= emit_idx_reg + IDX_W'(1);
            end
        end
    end

    // Store each event in arrival order
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && (scan_kind != kprt_pkg::KIND_NONE))
        begin
            ev_id_reg[ev_wr_idx]   <= scan_idx_reg;
            ev_kind_reg[ev_wr_idx] <= scan_kind;
        end
    end

    // Drive the event beat; an empty poll gives a single none event
    always_comb
    begin
        if (ev_cnt_reg == '0)
        begin
            button_id  = '0;
            event_kind = kprt_pkg::KIND_NONE;
        end
        else
        begin
            button_id  = kprt_pkg::ID_W'(ev_id_reg[emit_idx_reg]);
            event_kind = ev_kind_reg[emit_idx_reg];
        end
        held_mask = kprt_pkg::MASK_W'(held_reg);
        last      = status.emit_last;
    end

endmodule

/* rtl/kprt_checker.sv */
// Port-level checks of the key tracker and their binding to the top level.
`timescale 1ns / 1ps

module kprt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          poll_valid,
    input logic                          poll_ready,
    input logic                          evt_valid,
    input logic                          evt_ready,
    input logic [kprt_pkg::ID_W-1:0]     button_id,
    input logic [kprt_pkg::KIND_W-1:0]   event_kind,
    input logic [kprt_pkg::MASK_W-1:0]   held_mask,
    input logic                          last
);

    // A waiting event beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_ready) |=> (evt_valid && $stable(button_id) &&
            $stable(event_kind) && $stable(held_mask) && $stable(last)))
        else $error("stalled event beat changed");

    // No poll is taken while events of the previous one are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        poll_ready |-> !evt_valid)
        else $error("poll ready while events pending");

    // A taken poll is followed by a scan before any event
    assert property (@(posedge clk) disable iff (!rst_n)
        (poll_valid && poll_ready) |=> (!evt_valid && !poll_ready))
        else $error("event offered right after poll accept");

    // A none beat stands alone and names button zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && (event_kind == kprt_pkg::KIND_NONE)) |-> (last && (button_id == '0)))
        else $error("none event not alone");

    // The held mask stays fixed across the beats of one poll
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_ready && !last) |=> (evt_valid && $stable(held_mask)))
        else $error("held mask changed within a poll");

endmodule

bind key_press_repeat_release_tracker kprt_checker u_kprt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .poll_valid (poll.valid),
    .poll_ready (poll.ready),
    .evt_valid  (evt.valid),
    .evt_ready  (evt.ready),
    .button_id  (evt.button_id),
    .event_kind (evt.event_kind),
    .held_mask  (evt.held_mask),
    .last       (evt.last)
);

/* verif/kprt_event_checker.sv */
// Event checker for the key tracker: mirrors button timing, predicts event beats, compares.
`timescale 1ns / 1ps

module kprt_event_checker (
    input  logic   clk,
    input  logic   rst_n,
    kprt_poll_if   poll,
    kprt_event_if  evt,
    kprt_cfg_if    cfg,
    output int     fail_count,
    output int     pending,
    output int     polls_seen,
    output int     press_seen,
    output int     repeat_seen,
    output int     release_seen
);

    localparam int KEYS = kprt_pkg::NUM_BUTTONS_DEF;

    typedef struct packed {
        logic [kprt_pkg::ID_W-1:0]   button_id;
        logic [kprt_pkg::KIND_W-1:0] event_kind;
        logic [kprt_pkg::MASK_W-1:0] held_mask;
        logic                        last;
    } key_event_t;

    // Mirror of the block's registers and per-button timing
    logic [kprt_pkg::CFG_W-1:0] unseen_limit;
    logic [kprt_pkg::CFG_W-1:0] hold_delay;
    logic [kprt_pkg::CFG_W-1:0] rep_gap;
    logic [KEYS-1:0]            held;
    logic [kprt_pkg::NOW_W-1:0] seen_at [KEYS];
    logic [kprt_pkg::NOW_W-1:0] down_at [KEYS];
    logic [kprt_pkg::NOW_W-1:0] repeated_at [KEYS];

    key_event_t expected_events [$];

    // Apply one poll to the mirrored state and queue the event beats it causes
    function automatic void predict_poll(input logic [kprt_pkg::MASK_W-1:0] seen,
                                         input logic [kprt_pkg::NOW_W-1:0] now_val);
        logic [kprt_pkg::KIND_W-1:0] kinds [KEYS];
        logic [kprt_pkg::NOW_W-1:0]  held_for;
        logic [kprt_pkg::NOW_W-1:0]  rep_age;
        logic [kprt_pkg::NOW_W-1:0]  since_seen;
        int                          n_events;
        int                          k;
        key_event_t                  ev;

        // Latch newly pressed buttons and refresh last-seen times
        for (int i = 0; i < KEYS; i++)
        begin
            if (seen[i])
            begin
                if (!held[i])
                begin
                    held[i]    = 1'b1;
                    down_at[i] = now_val;
                end
                seen_at[i] = now_val;
            end
        end

        // Visit buttons in index order; press wins over repeat, repeat over release
        n_events = 0;
        for (int i = 0; i < KEYS; i++)
        begin
            kinds[i] = kprt_pkg::KIND_NONE;
            if (held[i])
            begin
                held_for   = now_val - down_at[i];
                rep_age    = now_val - repeated_at[i];
                since_seen = now_val - seen_at[i];
                if (held_for == '0)
                begin
                    kinds[i] = kprt_pkg::KIND_PRESS;
                end
                else if (held_for >= kprt_pkg::NOW_W'(hold_delay) &&
                         rep_age >= kprt_pkg::NOW_W'(rep_gap))
                begin
                    repeated_at[i] = now_val;
                    kinds[i]       = kprt_pkg::KIND_REPEAT;
                end
                else if (since_seen > kprt_pkg::NOW_W'(unseen_limit))
                begin
                    held[i]  = 1'b0;
                    kinds[i] = kprt_pkg::KIND_RELEASE;
                end
            end
            if (kinds[i] != kprt_pkg::KIND_NONE)
                n_events++;
        end

        // A quiet poll still yields one beat of kind none
        if (n_events == 0)
        begin
            ev.button_id  = '0;
            ev.event_kind = kprt_pkg::KIND_NONE;
            ev.held_mask  = held;
            ev.last       = 1'b1;
            expected_events.push_back(ev);
        end
        else
        begin
            k = 0;
            for (int i = 0; i < KEYS; i++)
            begin
                if (kinds[i] != kprt_pkg::KIND_NONE)
                begin
                    k++;
                    ev.button_id  = kprt_pkg::ID_W'(i);
                    ev.event_kind = kinds[i];
                    ev.held_mask  = held;
                    ev.last       = (k == n_events);
                    expected_events.push_back(ev);
                    case (kinds[i])
                        kprt_pkg::KIND_PRESS:   press_seen++;
                        kprt_pkg::KIND_REPEAT:  repeat_seen++;
                        kprt_pkg::KIND_RELEASE: release_seen++;
                        default: ;
                    endcase
                end
            end
        end
        polls_seen++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_event_t want;
        if (!rst_n)
        begin
            unseen_limit = kprt_pkg::RELEASE_TIMEOUT_RST;
            hold_delay   = kprt_pkg::REPEAT_DELAY_RST;
            rep_gap      = kprt_pkg::REPEAT_INTERVAL_RST;
            held         = '0;
            for (int i = 0; i < KEYS; i++)
            begin
                seen_at[i]     = '0;
                down_at[i]     = '0;
                repeated_at[i] = '0;
            end
            expected_events.delete();
            fail_count   = 0;
            pending      = 0;
            polls_seen   = 0;
            press_seen   = 0;
            repeat_seen  = 0;
            release_seen = 0;
        end
        else
        begin
            // Compare an event beat with the oldest expectation
            if (evt.valid && evt.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected event beat: button_id %0d event_kind %0d",
                           evt.button_id, evt.event_kind);
                    fail_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (evt.button_id !== want.button_id)
                    begin
                        $error("button_id mismatch: expected %0d, got %0d",
                               want.button_id, evt.button_id);
                        fail_count++;
                    end
                    if (evt.event_kind !== want.event_kind)
                    begin
                        $error("event_kind mismatch: expected %0d, got %0d",
                               want.event_kind, evt.event_kind);
                        fail_count++;
                    end
                    if (evt.held_mask !== want.held_mask)
                    begin
                        $error("held_mask mismatch: expected %03h, got %03h",
                               want.held_mask, evt.held_mask);
                        fail_count++;
                    end
                    if (evt.last !== want.last)
                    begin
                        $error("last mismatch: expected %0d, got %0d",
                               want.last, evt.last);
                        fail_count++;
                    end
                end
            end

            // Track register writes; an unmapped index is dropped
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    kprt_pkg::CFG_RELEASE_TIMEOUT: unseen_limit = cfg.data;
                    kprt_pkg::CFG_REPEAT_DELAY:    hold_delay   = cfg.data;
                    kprt_pkg::CFG_REPEAT_INTERVAL: rep_gap      = cfg.data;
                    default: ;
                endcase
            end

            if (poll.valid && poll.ready)
                predict_poll(poll.pressed_mask, poll.now_ms);

            pending = expected_events.size();
        end
    end

endmodule

/* verif/tb_key_press_repeat_release_tracker.sv */
// Testbench top for the key tracker: clock, reset, poll and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_key_press_repeat_release_tracker;

    localparam logic [kprt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int POLLS_PER_PHASE = 14;
    localparam int QUIET_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = kprt_pkg::NUM_BUTTONS_DEF + 8;

    logic clk = 1'b0;
    logic rst_n;

    kprt_poll_if  poll_ch ();
    kprt_event_if evt_ch ();
    kprt_cfg_if   cfg_ch ();

    int  mismatch_total;
    int  expected_left;
    int  polls_total;
    int  press_total;
    int  repeat_total;
    int  release_total;
    int  settings_applied = 0;
    int  stall_left;
    int  quiet_cycles;
    bit  idle_en;

    always #5 clk = ~clk;

    key_press_repeat_release_tracker DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .poll  (poll_ch),
        .evt   (evt_ch),
        .cfg   (cfg_ch)
    );

    kprt_event_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll         (poll_ch),
        .evt          (evt_ch),
        .cfg          (cfg_ch),
        .fail_count   (mismatch_total),
        .pending      (expected_left),
        .polls_seen   (polls_total),
        .press_seen   (press_total),
        .repeat_seen  (repeat_total),
        .release_seen (release_total)
    );

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Event sink: hold off ready for random stretches
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            evt_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            evt_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            evt_ch.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (poll_ch.valid && poll_ch.ready) || (evt_ch.valid && evt_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one poll beat, keeping valid high if it follows a beat back to back
    task automatic send_poll(input logic [kprt_pkg::MASK_W-1:0] mask,
                             input logic [kprt_pkg::NOW_W-1:0] stamp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            poll_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_ch.valid        <= 1'b1;
        poll_ch.pressed_mask <= mask;
        poll_ch.now_ms       <= stamp;
        do @(posedge clk); while (!poll_ch.ready);
    endtask

    // Drop valid and wait until every expected beat is out and the scan is over
    task automatic settle();
        poll_ch.valid <= 1'b0;
        @(posedge clk);
        wait (expected_left == 0);
        repeat (kprt_pkg::NUM_BUTTONS_DEF + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [kprt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kprt_pkg::CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Write all three registers, preceded by a write to the unmapped index
    task automatic write_settings(input logic [kprt_pkg::CFG_W-1:0] timeout_ms,
                                  input logic [kprt_pkg::CFG_W-1:0] delay_ms,
                                  input logic [kprt_pkg::CFG_W-1:0] interval_ms);
        write_reg(CFG_UNUSED, kprt_pkg::CFG_W'($urandom));
        write_reg(kprt_pkg::CFG_RELEASE_TIMEOUT, timeout_ms);
        write_reg(kprt_pkg::CFG_REPEAT_DELAY, delay_ms);
        write_reg(kprt_pkg::CFG_REPEAT_INTERVAL, interval_ms);
        cfg_ch.valid <= 1'b0;
        settings_applied++;
    endtask

    // One setting, then a run of polls with keys held over time and some noise
    task automatic run_random_phase(input logic [kprt_pkg::CFG_W-1:0] timeout_ms,
                                    input logic [kprt_pkg::CFG_W-1:0] delay_ms,
                                    input logic [kprt_pkg::CFG_W-1:0] interval_ms,
                                    input logic [kprt_pkg::NOW_W-1:0] start_ms,
                                    input bit idling);
        logic [kprt_pkg::NOW_W-1:0]  clock_ms;
        logic [kprt_pkg::MASK_W-1:0] keys_down;
        logic [kprt_pkg::MASK_W-1:0] mask;
        int                          span;
        int                          r;
        settle();
        idle_en <= idling;
        write_settings(timeout_ms, delay_ms, interval_ms);
        clock_ms  = start_ms;
        keys_down = '0;
        span = int'(timeout_ms);
        if (int'(delay_ms) > span)
            span = int'(delay_ms);
        if (int'(interval_ms) > span)
            span = int'(interval_ms);
        span = span + 16;
        repeat (POLLS_PER_PHASE)
        begin
            // Advance time: same stamp, small step, step on the scale of the
            // registers, or a wild jump
            r = $urandom_range(0, 99);
            if (r < 10)
                clock_ms = clock_ms;
            else if (r < 60)
                clock_ms = clock_ms + $urandom_range(1, span / 8 + 1);
            else if (r < 92)
                clock_ms = clock_ms + $urandom_range(1, span);
            else
                clock_ms = clock_ms + $urandom;
            // Flip a few keys; sometimes bounce or send a noise mask
            keys_down = keys_down ^ kprt_pkg::MASK_W'($urandom & $urandom);
            r = $urandom_range(0, 99);
            if (r < 12)
                mask = kprt_pkg::MASK_W'($urandom);
            else if (r < 22)
                mask = keys_down & kprt_pkg::MASK_W'($urandom);
            else
                mask = keys_down;
            send_poll(mask, clock_ms);
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        idle_en              = 1'b1;
        evt_ch.ready         = 1'b0;
        poll_ch.valid        = 1'b0;
        poll_ch.pressed_mask = '0;
        poll_ch.now_ms       = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = kprt_pkg::CFG_RELEASE_TIMEOUT;
        cfg_ch.data          = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: quiet poll, all twelve pressed, press again at the same
        // time while unseen, repeat timed from time zero, releases, wrap of time
        send_poll(12'h000, 32'd0);
        send_poll(12'hFFF, 32'd0);
        send_poll(12'h000, 32'd0);
        send_poll(12'h001, 32'd100);
        send_poll(12'h001, 32'd400);
        send_poll(12'h001, 32'd430);
        send_poll(12'h001, 32'd450);
        send_poll(12'h000, 32'd601);
        send_poll(12'h800, 32'hFFFF_FFF0);
        send_poll(12'h000, 32'h0000_0100);

        // All-zero registers: repeat on every poll with a later stamp than the press
        settle();
        write_settings(16'd0, 16'd0, 16'd0);
        send_poll(12'hA5A, 32'd1000);
        send_poll(12'hA5A, 32'd1000);
        send_poll(12'h5A5, 32'd1001);
        send_poll(12'h000, 32'd1002);

        // All-ones registers: long holds and timeouts at the limit
        settle();
        write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_poll(12'hFFF, 32'd2000);
        send_poll(12'h0F0, 32'd2000 + 32'd65535);
        send_poll(12'h00F, 32'd2000 + 32'd65536);
        send_poll(12'h000, 32'd2000 + 32'd131072);
        send_poll(12'h000, 32'hFFFF_FFFF);

        // Random phases; the second and fifth run with no idling on either side
        run_random_phase(16'($urandom_range(20, 300)), 16'($urandom_range(50, 600)),
                         16'($urandom_range(1, 100)), $urandom, 1'b1);
        run_random_phase(16'd0, 16'd0, 16'd0, $urandom, 1'b0);
        run_random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, $urandom, 1'b1);
        run_random_phase(16'($urandom), 16'($urandom), 16'($urandom), $urandom, 1'b1);
        run_random_phase(16'hFFFF, 16'd0, 16'hFFFF, $urandom, 1'b0);
        run_random_phase(16'd150, 16'd400, 16'd50, 32'hFFFF_FF00, 1'b1);

        // Drain and report
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d polls giving %0d press, %0d repeat and %0d release events",
                 polls_total, press_total, repeat_total, release_total);
        $display("Register settings applied: %0d, all-zero and all-ones among them",
                 settings_applied);
        if (mismatch_total == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
